FILE: design/bmrf_pkg.sv
// ---------------------------------------------------------------------------
// Bitmap rect fill and rotate package
// Screen geometry, command codes, shift tables and controller interface types.
// ---------------------------------------------------------------------------
package bmrf_pkg;

   localparam int WIDTH  = 50;
   localparam int HEIGHT = 6;

   localparam int ARG_W = 6;
   localparam int COL_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam int ROW_W = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
   localparam int CNT_W = $clog2(WIDTH * HEIGHT + 1);
   localparam int LIT_W = 9;
   localparam int LIT_MAX = 511;
   localparam int ARG_VALUES = 1 << ARG_W;

   typedef enum logic [1:0] {
      CMD_RECT = 2'd0,
      CMD_ROW  = 2'd1,
      CMD_COL  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_PASS,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic prep;
      logic step;
   } dp_cmd_type;

   typedef struct packed {
      logic last_row;
   } dp_status_type;

   typedef logic [COL_W-1:0] row_shift_table_type [ARG_VALUES];
   typedef logic [ROW_W-1:0] col_shift_table_type [ARG_VALUES];

   function automatic row_shift_table_type build_row_shift_table();
      row_shift_table_type t;
      for (int i = 0; i < ARG_VALUES; i++) begin
         t[i] = COL_W'(i % WIDTH);
      end
      return t;
   endfunction

   function automatic col_shift_table_type build_col_shift_table();
      col_shift_table_type t;
      for (int i = 0; i < ARG_VALUES; i++) begin
         t[i] = ROW_W'(i % HEIGHT);
      end
      return t;
   endfunction

   localparam row_shift_table_type ROW_SHIFT_TABLE = build_row_shift_table();
   localparam col_shift_table_type COL_SHIFT_TABLE = build_col_shift_table();

endpackage

FILE: design/bmrf_ctrl.sv
// ---------------------------------------------------------------------------
// Bitmap rect fill and rotate controller
// Sequences accept, column preparation, the row pass and the result beat.
// ---------------------------------------------------------------------------
module bmrf_ctrl import bmrf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          rsp_valid
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_PASS;
         end
         ST_PASS: begin
            cmd.step = 1'b1;
            if (status.last_row) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/bmrf_datapath.sv
// ---------------------------------------------------------------------------
// Bitmap rect fill and rotate datapath
// Circular line of row registers updated one row per step, with the lit count.
// ---------------------------------------------------------------------------
module bmrf_datapath import bmrf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  logic [1:0]        req_kind,
   input  logic [ARG_W-1:0]  req_arg_a,
   input  logic [ARG_W-1:0]  req_arg_b,
   output dp_status_type     status,
   output logic [LIT_W-1:0]  rsp_lit_count
);

   function automatic logic [WIDTH-1:0] col_select(input logic [ARG_W-1:0] col);
      logic [WIDTH-1:0] m;
      for (int x = 0; x < WIDTH; x++) begin
         m[x] = (ARG_W'(x) == col);
      end
      return m;
   endfunction

   function automatic logic [CNT_W-1:0] popcount(input logic [WIDTH-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int x = 0; x < WIDTH; x++) begin
         n = n + CNT_W'(v[x]);
      end
      return n;
   endfunction

   logic [WIDTH-1:0]  rows_ff [HEIGHT];
   logic [WIDTH-1:0]  new_row;
   cmd_kind_type      kind_ff;
   logic [ARG_W-1:0]  a_ff;
   logic [ARG_W-1:0]  b_ff;
   logic [COL_W-1:0]  row_shift_ff;
   logic [ROW_W-1:0]  col_shift_ff;
   logic [HEIGHT-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  y_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [WIDTH-1:0]  rect_mask;
   logic [WIDTH-1:0]  col_mask;
   logic [2*WIDTH-1:0]  row_dbl;
   logic [2*HEIGHT-1:0] col_dbl;

   always_comb begin
      for (int x = 0; x < WIDTH; x++) begin
         rect_mask[x] = (ARG_W'(x) < a_ff);
      end
      col_mask = col_select(a_ff);
      row_dbl  = {rows_ff[0], rows_ff[0]} << row_shift_ff;
      col_dbl  = {col_ff, col_ff} << col_shift_ff;
      new_row  = rows_ff[0];
      case (kind_ff)
         CMD_RECT: begin
            if (ARG_W'(y_ff) < b_ff) begin
               new_row = rows_ff[0] | rect_mask;
            end
         end
         CMD_ROW: begin
            if (ARG_W'(y_ff) == a_ff) begin
               new_row = row_dbl[2*WIDTH-1:WIDTH];
            end
         end
         CMD_COL: begin
            new_row = (rows_ff[0] & ~col_mask) | (col_ff[0] ? col_mask : '0);
         end
         default: begin
            new_row = rows_ff[0];
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < HEIGHT; i++) begin
         col_in[i] = |(rows_ff[i] & col_select(req_arg_a));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HEIGHT; i++) begin
            rows_ff[i] <= '0;
         end
         y_ff     <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         kind_ff      <= cmd_kind_type'(req_kind);
         a_ff         <= req_arg_a;
         b_ff         <= req_arg_b;
         row_shift_ff <= ROW_SHIFT_TABLE[req_arg_b];
         col_shift_ff <= COL_SHIFT_TABLE[req_arg_b];
         col_ff       <= col_in;
         y_ff         <= '0;
         count_ff     <= '0;
      end else if (cmd.prep) begin
         col_ff <= col_dbl[2*HEIGHT-1:HEIGHT];
      end else if (cmd.step) begin
         for (int i = 0; i < HEIGHT - 1; i++) begin
            rows_ff[i] <= rows_ff[i+1];
         end
         rows_ff[HEIGHT-1] <= new_row;
         col_ff   <= col_ff >> 1;
         y_ff     <= y_ff + ROW_W'(1);
         count_ff <= count_ff + popcount(new_row);
      end
   end

   assign status.last_row = (y_ff == ROW_W'(HEIGHT - 1));
   assign rsp_lit_count   = (32'(count_ff) > LIT_MAX) ? LIT_W'(LIT_MAX) : LIT_W'(count_ff);

endmodule

FILE: design/bitmap_rect_fill_and_rotate_unit.sv
// ---------------------------------------------------------------------------
// Bitmap rect fill and rotate unit
// One-bit HEIGHT by WIDTH bitmap with rect fill, row and column rotate.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The result beat,
// the count of lit pixels after the command, appears on rsp_lit_count with
// rsp_valid high for exactly one cycle, after the column preparation step
// and the row pass, and busy drops the cycle after it, so the unit takes no
// new command until the result beat is out. In the row pass the rows
// circulate through one update and count stage, one row per cycle, after a
// step that rotates the captured column. The receiver cannot stall the
// result beat, so it must take it in that cycle.
module bitmap_rect_fill_and_rotate_unit import bmrf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_kind,
   input  logic [ARG_W-1:0] req_arg_a,
   input  logic [ARG_W-1:0] req_arg_b,
   output logic             rsp_valid,
   output logic [LIT_W-1:0] rsp_lit_count
);

   dp_cmd_type    cmd;
   dp_status_type status;

   bmrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bmrf_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_kind      (req_kind),
      .req_arg_a     (req_arg_a),
      .req_arg_b     (req_arg_b),
      .status        (status),
      .rsp_lit_count (rsp_lit_count)
   );

`ifndef SYNTHESIS
   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after a command was taken");

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(HEIGHT + 2) rsp_valid)
      else $error("result beat missing at the expected cycle");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result beat longer than one cycle");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_lit_count) <= WIDTH * HEIGHT))
      else $error("lit count exceeds the screen size");
`endif

endmodule

FILE: bench/tb_bitmap_rect_fill_and_rotate_unit.sv
// ---------------------------------------------------------------------------
// Bitmap rect fill and rotate unit testbench
// Sends rect fill, row rotate and column rotate commands and checks the lit
// pixel count of every result beat against a bitmap kept inside the bench.
// ---------------------------------------------------------------------------
module tb_bitmap_rect_fill_and_rotate_unit import bmrf_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [1:0]       req_kind;
   logic [ARG_W-1:0] req_arg_a;
   logic [ARG_W-1:0] req_arg_b;
   logic             rsp_valid;
   logic [LIT_W-1:0] rsp_lit_count;

   logic [WIDTH-1:0] screen [HEIGHT];
   logic [LIT_W-1:0] pending_counts [$];
   int               error_count;

   bitmap_rect_fill_and_rotate_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_arg_a     (req_arg_a),
      .req_arg_b     (req_arg_b),
      .rsp_valid     (rsp_valid),
      .rsp_lit_count (rsp_lit_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [LIT_W-1:0] apply_command(input cmd_kind_type kind,
                                                      input int a, input int b);
      int               cols;
      int               rows;
      int               shift;
      int               total;
      logic [WIDTH-1:0] turned;
      logic             line [HEIGHT];
      case (kind)
         CMD_RECT: begin
            cols = (a > WIDTH) ? WIDTH : a;
            rows = (b > HEIGHT) ? HEIGHT : b;
            for (int y = 0; y < rows; y++) begin
               for (int x = 0; x < cols; x++) begin
                  screen[y][x] = 1'b1;
               end
            end
         end
         CMD_ROW: begin
            if (a < HEIGHT) begin
               shift = b % WIDTH;
               turned = '0;
               for (int x = 0; x < WIDTH; x++) begin
                  turned[(x + shift) % WIDTH] = screen[a][x];
               end
               screen[a] = turned;
            end
         end
         CMD_COL: begin
            if (a < WIDTH) begin
               shift = b % HEIGHT;
               for (int y = 0; y < HEIGHT; y++) begin
                  line[(y + shift) % HEIGHT] = screen[y][a];
               end
               for (int y = 0; y < HEIGHT; y++) begin
                  screen[y][a] = line[y];
               end
            end
         end
         default: begin
         end
      endcase
      total = 0;
      for (int y = 0; y < HEIGHT; y++) begin
         for (int x = 0; x < WIDTH; x++) begin
            total += screen[y][x];
         end
      end
      if (total > LIT_MAX) begin
         total = LIT_MAX;
      end
      return LIT_W'(total);
   endfunction

   // The command stays on the bus until a rising edge sees busy low.
   task automatic send_command(input cmd_kind_type kind,
                               input logic [ARG_W-1:0] a, input logic [ARG_W-1:0] b);
      @(negedge clock);
      start     <= 1'b1;
      req_kind  <= kind;
      req_arg_a <= a;
      req_arg_b <= b;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      pending_counts.push_back(apply_command(kind, a, b));
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      start     <= 1'b0;
      req_kind  <= 2'($urandom);
      req_arg_a <= ARG_W'($urandom);
      req_arg_b <= ARG_W'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_random_command();
      int               pick;
      cmd_kind_type     kind;
      logic [ARG_W-1:0] a;
      logic [ARG_W-1:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         kind = CMD_RECT;
         pick = $urandom_range(0, 39);
         if (pick < 2) begin
            a = ARG_W'($urandom_range(0, 63));
            b = ARG_W'($urandom_range(0, 2));
         end else if (pick < 3) begin
            a = ARG_W'($urandom_range(0, 3));
            b = ARG_W'($urandom_range(0, 63));
         end else begin
            a = ARG_W'($urandom_range(0, 10));
            b = ARG_W'($urandom_range(0, HEIGHT + 1));
         end
      end else if (pick < 50) begin
         kind = CMD_ROW;
         a = ($urandom_range(0, 9) < 7) ? ARG_W'($urandom_range(0, HEIGHT - 1))
                                        : ARG_W'($urandom_range(0, 63));
         b = ARG_W'($urandom_range(0, 63));
      end else if (pick < 97) begin
         kind = CMD_COL;
         a = ($urandom_range(0, 9) < 8) ? ARG_W'($urandom_range(0, WIDTH - 1))
                                        : ARG_W'($urandom_range(0, 63));
         b = ARG_W'($urandom_range(0, 63));
      end else begin
         kind = CMD_NONE;
         a = ARG_W'($urandom);
         b = ARG_W'($urandom);
      end
      send_command(kind, a, b);
   endtask

   task automatic test_empty_screen();
      send_command(CMD_NONE, 0, 0);
      send_command(CMD_ROW, 0, 17);
      send_command(CMD_COL, 3, 4);
   endtask

   task automatic test_rect_fill();
      send_command(CMD_RECT, 0, 5);
      send_command(CMD_RECT, 7, 0);
      send_command(CMD_RECT, 3, 2);
      send_command(CMD_RECT, 63, 1);
      send_command(CMD_RECT, 2, 63);
   endtask

   task automatic test_row_rotate();
      send_command(CMD_ROW, 0, 1);
      send_command(CMD_ROW, 1, 50);
      send_command(CMD_ROW, 1, 63);
      send_command(CMD_ROW, HEIGHT - 1, WIDTH - 1);
      send_command(CMD_ROW, HEIGHT, 5);
      send_command(CMD_ROW, 63, 63);
   endtask

   task automatic test_col_rotate();
      send_command(CMD_COL, 0, HEIGHT);
      send_command(CMD_COL, 2, 1);
      send_command(CMD_COL, WIDTH - 1, 63);
      send_command(CMD_COL, WIDTH, 3);
      send_command(CMD_COL, 63, 0);
      send_command(CMD_NONE, 63, 63);
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) begin
            hold_off($urandom_range(1, 13));
         end
         send_random_command();
      end
   endtask

   task automatic test_back_to_back(input int count);
      repeat (count) begin
         send_random_command();
      end
   endtask

   task automatic test_full_screen();
      send_command(CMD_RECT, 63, 63);
      send_command(CMD_ROW, 3, 7);
      send_command(CMD_COL, 10, 3);
      send_command(CMD_NONE, 0, 0);
   endtask

   always @(posedge clock) begin
      logic [LIT_W-1:0] expected;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (pending_counts.size() == 0) begin
            report_mismatch($sformatf("result beat %0d with no command pending",
                                      rsp_lit_count));
         end else begin
            expected = pending_counts.pop_front();
            if (rsp_lit_count !== expected) begin
               report_mismatch($sformatf("lit_count %0d, expected %0d",
                                         rsp_lit_count, expected));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int drain_cycles;
      error_count = 0;
      for (int y = 0; y < HEIGHT; y++) begin
         screen[y] = '0;
      end
      reset     = 1'b1;
      start     = 1'b0;
      req_kind  = CMD_NONE;
      req_arg_a = '0;
      req_arg_b = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_screen();
      test_rect_fill();
      test_row_rotate();
      test_col_rotate();
      test_random_mix(800);
      test_back_to_back(100);
      test_full_screen();

      @(negedge clock);
      start <= 1'b0;
      drain_cycles = 0;
      while (pending_counts.size() != 0 && drain_cycles < 1000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (HEIGHT + 6) @(posedge clock);
      if (pending_counts.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_counts.size()));
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
